// ===== sv/kup_pkg.sv =====
// Shared types, register indexes and the saturation helper of the 2x2 Kalman update.
// Depends on nothing; every other file of the block imports it.
package kup_pkg;

   // Q-format value and wide product.
   typedef logic signed [31:0] fix_type;
   typedef logic signed [63:0] prod_type;
   typedef fix_type vec_type [2];
   typedef fix_type mat_type [2][2];

   // State, covariance and innovation of one item.
   typedef struct {
      vec_type x;
      mat_type p;
      vec_type v;
   } item_type;

   // What travels beside the divider: the item, P*H^T and the singular flag.
   typedef struct {
      item_type item;
      mat_type  pht;
      logic     sing;
   } carry_type;

   // Configuration register indexes.
   localparam logic [7:0] CSR_NOISE_00 = 8'd0;
   localparam logic [7:0] CSR_NOISE_01 = 8'd1;
   localparam logic [7:0] CSR_NOISE_10 = 8'd2;
   localparam logic [7:0] CSR_NOISE_11 = 8'd3;

   localparam fix_type FIX_MAX = 32'sh7FFF_FFFF;
   localparam fix_type FIX_MIN = 32'sh8000_0000;
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   // Clamp a wide signed sum to the 32-bit range.
   function automatic fix_type sat32(input logic signed [65:0] val);
      fix_type res;
      if (val > SAT_HI) begin
         res = FIX_MAX;
      end else if (val < SAT_LO) begin
         res = FIX_MIN;
      end else begin
         res = fix_type'(val[31:0]);
      end
      return res;
   endfunction

endpackage

// ===== sv/kup_front.sv =====
// Front pipeline: P*H^T, S = H*P*H^T + R and the determinant of S, seven stages.
// Depends on kup_pkg.
module kup_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  kup_pkg::vec_type   in_x,
   input  kup_pkg::mat_type   in_p,
   input  kup_pkg::vec_type   in_v,
   input  kup_pkg::mat_type   in_h,
   input  kup_pkg::mat_type   in_r,
   output logic               out_valid,
   output kup_pkg::carry_type out_carry,
   output kup_pkg::mat_type   out_s,
   output logic signed [63:0] out_den
);
   import kup_pkg::*;

   logic [6:0] vld_ff;
   item_type   it1_ff, it2_ff;
   mat_type    h1_ff, h2_ff, h3_ff;
   carry_type  c3_ff, c4_ff, c5_ff, c6_ff, c7_ff;
   prod_type   pp_in [2][2][2];
   prod_type   pp_ff [2][2][2];
   mat_type    pht_in;
   prod_type   hp_in [2][2][2];
   prod_type   hp_ff [2][2][2];
   mat_type    s_in, s5_ff, s6_ff, s7_ff;
   prod_type   dp0_in, dp1_in, dp0_ff, dp1_ff;
   logic signed [63:0] d_in, d_ff;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   // Stage two: the eight products of P and H.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 2; k++) begin
               pp_in[i][j][k] = 64'(it1_ff.p[i][k]) * 64'(h1_ff[j][k]);
            end
         end
      end
   end

   // Stage three: scale, add and clamp into P*H^T.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            pht_in[i][j] = sat32(66'(pp_ff[i][j][0] >>> FRAC_BITS)
                               + 66'(pp_ff[i][j][1] >>> FRAC_BITS));
         end
      end
   end

   // Stage four: products of H and P*H^T.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 2; k++) begin
               hp_in[i][j][k] = 64'(h3_ff[i][k]) * 64'(c3_ff.pht[k][j]);
            end
         end
      end
   end

   // Stage five: S with the noise matrix added.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            s_in[i][j] = sat32(66'(hp_ff[i][j][0] >>> FRAC_BITS)
                             + 66'(hp_ff[i][j][1] >>> FRAC_BITS)
                             + 66'(in_r[i][j]));
         end
      end
   end

   // Stages six and seven: determinant products, then their difference.
   always_comb begin
      dp0_in = 64'(s5_ff[0][0]) * 64'(s5_ff[1][1]);
      dp1_in = 64'(s5_ff[0][1]) * 64'(s5_ff[1][0]);
      d_in   = (dp0_ff >>> FRAC_BITS) - (dp1_ff >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      it1_ff <= '{x: in_x, p: in_p, v: in_v};
      h1_ff  <= in_h;
      it2_ff <= it1_ff;
      h2_ff  <= h1_ff;
      pp_ff  <= pp_in;
      c3_ff  <= '{item: it2_ff, pht: pht_in, sing: 1'b0};
      h3_ff  <= h2_ff;
      hp_ff  <= hp_in;
      c4_ff  <= c3_ff;
      s5_ff  <= s_in;
      c5_ff  <= c4_ff;
      dp0_ff <= dp0_in;
      dp1_ff <= dp1_in;
      s6_ff  <= s5_ff;
      c6_ff  <= c5_ff;
      d_ff   <= d_in;
      s7_ff  <= s6_ff;
      c7_ff  <= c6_ff;
   end

   // A zero determinant marks the item singular.
   always_comb begin
      out_carry      = c7_ff;
      out_carry.sing = (d_ff == '0);
   end

   assign out_valid = vld_ff[6];
   assign out_s     = s7_ff;
   assign out_den   = d_ff;

endmodule

// ===== sv/kup_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, truncation toward zero.
// Depends on kup_pkg.
module kup_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  kup_pkg::fix_type           num,
   input  logic                       num_flip,
   input  logic signed [63:0]         den,
   output logic [32+FRAC_BITS-1:0]    quo_mag,
   output logic                       quo_neg
);
   import kup_pkg::*;

   localparam int NW  = 32 + FRAC_BITS;
   localparam int DMW = 64 - FRAC_BITS;

   logic [32:0]    num_ext;
   logic [31:0]    num_mag;
   logic [63:0]    den_abs;
   logic [DMW-1:0] rem_ff [NW-1];
   logic [DMW-1:0] dm_ff  [NW-1];
   logic [NW-1:0]  nq_ff  [NW];
   logic           neg_ff [NW];

   // Magnitudes; step zero forms the sign and shifts the numerator up by FRAC_BITS.
   always_comb begin
      num_ext = 33'(num);
      num_mag = num_ext[32] ? 32'(-num_ext) : num_ext[31:0];
      den_abs = den[63] ? 64'(-den) : 64'(den);
   end

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [DMW-1:0] rem_src, dm_src, rem_in;
      logic [NW-1:0]  nq_src, nq_in;
      logic           neg_src, ge;
      logic [DMW:0]   trial;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign dm_src  = den_abs[DMW-1:0];
         assign nq_src  = {num_mag, {FRAC_BITS{1'b0}}};
         assign neg_src = num[31] ^ num_flip ^ den[63];
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign dm_src  = dm_ff[k-1];
         assign nq_src  = nq_ff[k-1];
         assign neg_src = neg_ff[k-1];
      end

      // Shift in one dividend bit and subtract where it fits.
      always_comb begin
         trial  = {rem_src, nq_src[NW-1]};
         ge     = (trial >= {1'b0, dm_src});
         rem_in = ge ? DMW'(trial - {1'b0, dm_src}) : trial[DMW-1:0];
         nq_in  = {nq_src[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         nq_ff[k]  <= nq_in;
         neg_ff[k] <= neg_src;
      end

      if (k < NW - 1) begin : g_keep
         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            dm_ff[k]  <= dm_src;
         end
      end
   end

   assign quo_mag = nq_ff[NW-1];
   assign quo_neg = neg_ff[NW-1];

endmodule

// ===== sv/kup_back.sv =====
// Back pipeline: clamp the inverse, form the gain and the updated state and covariance.
// Depends on kup_pkg.
module kup_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  kup_pkg::carry_type      in_carry,
   input  logic [32+FRAC_BITS-1:0] in_quo [4],
   input  logic                    in_neg [4],
   output logic                    out_valid,
   output kup_pkg::vec_type        out_x,
   output kup_pkg::mat_type        out_p,
   output logic                    out_sing
);
   import kup_pkg::*;

   localparam int NW = 32 + FRAC_BITS;
   localparam logic [NW-1:0] QPOS = NW'(32'h7FFF_FFFF);
   localparam logic [NW-1:0] QNEG = NW'(32'h8000_0000);

   logic [3:0] vld_ff;
   carry_type  c1_ff, c2_ff, c3_ff, c4_ff;
   mat_type    si_in, si_ff;
   prod_type   pw_in [2][2][2];
   prod_type   pw_ff [2][2][2];
   mat_type    w_in, w_ff;
   prod_type   wv_in [2][2];
   prod_type   wv_ff [2][2];
   prod_type   wp_in [2][2][2];
   prod_type   wp_ff [2][2][2];
   vec_type    nx_in, nx_ff;
   mat_type    np_in, np_ff;
   logic       sing_ff, out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[2:0], in_valid};
         out_vld_ff <= vld_ff[3];
      end
   end

   // Stage one: signed, clamped entries of S inverse.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (!in_neg[k]) begin
            si_in[k/2][k%2] = (in_quo[k] > QPOS) ? FIX_MAX : signed'(in_quo[k][31:0]);
         end else begin
            si_in[k/2][k%2] = (in_quo[k] > QNEG) ? FIX_MIN : -signed'(in_quo[k][31:0]);
         end
      end
   end

   // Stage two: products of P*H^T and S inverse.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            for (int m = 0; m < 2; m++) begin
               pw_in[i][j][m] = 64'(c1_ff.pht[i][m]) * 64'(si_ff[m][j]);
            end
         end
      end
   end

   // Stage three: the gain.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            w_in[i][j] = sat32(66'(pw_ff[i][j][0] >>> FRAC_BITS)
                             + 66'(pw_ff[i][j][1] >>> FRAC_BITS));
         end
      end
   end

   // Stage four: gain times innovation and gain times (P*H^T)^T.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int k = 0; k < 2; k++) begin
            wv_in[i][k] = 64'(w_ff[i][k]) * 64'(c3_ff.item.v[k]);
            for (int j = 0; j < 2; j++) begin
               wp_in[i][j][k] = 64'(w_ff[i][k]) * 64'(c3_ff.pht[j][k]);
            end
         end
      end
   end

   // Stage five: corrected state and covariance, or the inputs when singular.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         nx_in[i] = sat32(66'(c4_ff.item.x[i])
                        + 66'(wv_ff[i][0] >>> FRAC_BITS)
                        + 66'(wv_ff[i][1] >>> FRAC_BITS));
         if (c4_ff.sing) begin
            nx_in[i] = c4_ff.item.x[i];
         end
         for (int j = 0; j < 2; j++) begin
            np_in[i][j] = sat32(66'(c4_ff.item.p[i][j])
                              - 66'(wp_ff[i][j][0] >>> FRAC_BITS)
                              - 66'(wp_ff[i][j][1] >>> FRAC_BITS));
            if (c4_ff.sing) begin
               np_in[i][j] = c4_ff.item.p[i][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      si_ff   <= si_in;
      c1_ff   <= in_carry;
      pw_ff   <= pw_in;
      c2_ff   <= c1_ff;
      w_ff    <= w_in;
      c3_ff   <= c2_ff;
      wv_ff   <= wv_in;
      wp_ff   <= wp_in;
      c4_ff   <= c3_ff;
      nx_ff   <= nx_in;
      np_ff   <= np_in;
      sing_ff <= c4_ff.sing;
   end

   assign out_valid = out_vld_ff;
   assign out_x     = nx_ff;
   assign out_p     = np_ff;
   assign out_sing  = sing_ff;

endmodule

// ===== sv/kalman_update_2x2_top.sv =====
// Top level of the 2x2 Kalman measurement update: noise registers, front pipeline,
// four dividers with the matching delay line, and back pipeline. Depends on kup_pkg.
//
// Usage: an item (state, covariance, innovation, Jacobian) is taken at each rising
// edge with start high; busy is always low, so one item may enter every cycle.
// The noise matrix is written through csr_wr_en, csr_index and csr_wdata; the user
// must do so only while no item is in flight, as the block does not enforce it.
// Indexes above three are ignored. Each result is shown for one cycle with
// rsp_strobe high, in input order, after passing the seven front stages, the
// divider of 32 + FRAC_BITS stages (one quotient bit each) and the five back
// stages; throughput is one item per cycle. The receiver cannot stall the result.
// Reset clears the noise matrix and every valid bit; items in flight are dropped.
// A zero determinant sets rsp_singular and returns state and covariance unchanged.
module kalman_update_2x2_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  kup_pkg::fix_type    req_state_x0,
   input  kup_pkg::fix_type    req_state_x1,
   input  kup_pkg::fix_type    req_cov_00,
   input  kup_pkg::fix_type    req_cov_01,
   input  kup_pkg::fix_type    req_cov_10,
   input  kup_pkg::fix_type    req_cov_11,
   input  kup_pkg::fix_type    req_innov_0,
   input  kup_pkg::fix_type    req_innov_1,
   input  kup_pkg::fix_type    req_jac_00,
   input  kup_pkg::fix_type    req_jac_01,
   input  kup_pkg::fix_type    req_jac_10,
   input  kup_pkg::fix_type    req_jac_11,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic                rsp_strobe,
   output kup_pkg::fix_type    rsp_new_x0,
   output kup_pkg::fix_type    rsp_new_x1,
   output kup_pkg::fix_type    rsp_new_cov_00,
   output kup_pkg::fix_type    rsp_new_cov_01,
   output kup_pkg::fix_type    rsp_new_cov_10,
   output kup_pkg::fix_type    rsp_new_cov_11,
   output logic                rsp_singular
);
   import kup_pkg::*;

   localparam int NW = 32 + FRAC_BITS;

   mat_type            noise_ff;
   vec_type            req_x, req_v;
   mat_type            req_p, req_h;
   logic               fr_valid;
   carry_type          fr_carry;
   mat_type            fr_s;
   logic signed [63:0] fr_den;
   fix_type            div_num [4];
   logic               div_flip [4];
   logic [NW-1:0]      div_quo [4];
   logic               div_neg [4];
   carry_type          dly_ff [NW];
   logic [NW-1:0]      dly_vld_ff;
   vec_type            bk_x;
   mat_type            bk_p;

   assign busy = 1'b0;

   // Noise matrix registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= '{'{32'sd0, 32'sd0}, '{32'sd0, 32'sd0}};
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NOISE_00: noise_ff[0][0] <= fix_type'(csr_wdata);
            CSR_NOISE_01: noise_ff[0][1] <= fix_type'(csr_wdata);
            CSR_NOISE_10: noise_ff[1][0] <= fix_type'(csr_wdata);
            CSR_NOISE_11: noise_ff[1][1] <= fix_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Gather the item fields into vectors and matrices.
   always_comb begin
      req_x = '{req_state_x0, req_state_x1};
      req_v = '{req_innov_0, req_innov_1};
      req_p = '{'{req_cov_00, req_cov_01}, '{req_cov_10, req_cov_11}};
      req_h = '{'{req_jac_00, req_jac_01}, '{req_jac_10, req_jac_11}};
   end

   kup_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_x      (req_x),
      .in_p      (req_p),
      .in_v      (req_v),
      .in_h      (req_h),
      .in_r      (noise_ff),
      .out_valid (fr_valid),
      .out_carry (fr_carry),
      .out_s     (fr_s),
      .out_den   (fr_den)
   );

   // Adjugate numerators: S11, -S01, -S10, S00.
   always_comb begin
      div_num[0]  = fr_s[1][1];
      div_flip[0] = 1'b0;
      div_num[1]  = fr_s[0][1];
      div_flip[1] = 1'b1;
      div_num[2]  = fr_s[1][0];
      div_flip[2] = 1'b1;
      div_num[3]  = fr_s[0][0];
      div_flip[3] = 1'b0;
   end

   for (genvar k = 0; k < 4; k++) begin : g_div
      kup_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock    (clock),
         .num      (div_num[k]),
         .num_flip (div_flip[k]),
         .den      (fr_den),
         .quo_mag  (div_quo[k]),
         .quo_neg  (div_neg[k])
      );
   end

   // Delay line that keeps each item beside its quotients.
   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff <= '0;
      end else begin
         dly_vld_ff <= {dly_vld_ff[NW-2:0], fr_valid};
      end
   end

   always_ff @(posedge clock) begin
      dly_ff[0] <= fr_carry;
      for (int k = 1; k < NW; k++) begin
         dly_ff[k] <= dly_ff[k-1];
      end
   end

   kup_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dly_vld_ff[NW-1]),
      .in_carry  (dly_ff[NW-1]),
      .in_quo    (div_quo),
      .in_neg    (div_neg),
      .out_valid (rsp_strobe),
      .out_x     (bk_x),
      .out_p     (bk_p),
      .out_sing  (rsp_singular)
   );

   assign rsp_new_x0     = bk_x[0];
   assign rsp_new_x1     = bk_x[1];
   assign rsp_new_cov_00 = bk_p[0][0];
   assign rsp_new_cov_01 = bk_p[0][1];
   assign rsp_new_cov_10 = bk_p[1][0];
   assign rsp_new_cov_11 = bk_p[1][1];

endmodule
